@@ hw/rtl/pulsed_actuator_hysteresis_controller_macros.svh @@
// Assertion macros shared by the checker of the pulsed actuator controller.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef PULSED_ACTUATOR_HYSTERESIS_CONTROLLER_MACROS_SVH
`define PULSED_ACTUATOR_HYSTERESIS_CONTROLLER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PAHC_ASSERT_SAME(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PAHC_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/pahc_pkg.sv @@
// Shared types and constants of the pulsed actuator hysteresis controller.
// No dependencies; every RTL module imports this package.
`timescale 1ns / 1ps

package pahc_pkg;

  // Directions of the actuator.
  localparam logic [1:0] DIR_LOCKED = 2'd0;
  localparam logic [1:0] DIR_LEFT   = 2'd1;
  localparam logic [1:0] DIR_RIGHT  = 2'd2;

  // Error codes.
  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_SENSOR_A = 3'd1;
  localparam logic [2:0] ERR_SENSOR_B = 3'd2;
  localparam logic [2:0] ERR_SENSOR_AB = 3'd3;
  localparam logic [2:0] ERR_STALL    = 3'd4;
  localparam logic [2:0] ERR_OVERTIME = 3'd5;

  // Register indexes of the configuration port.
  localparam logic [2:0] REG_SETPOINT     = 3'd0;
  localparam logic [2:0] REG_HYST_UP      = 3'd1;
  localparam logic [2:0] REG_HYST_DOWN    = 3'd2;
  localparam logic [2:0] REG_PULSE_LENGTH = 3'd3;
  localparam logic [2:0] REG_PULSE_GAP    = 3'd4;
  localparam logic [2:0] REG_STALL_LIMIT  = 3'd5;
  localparam logic [2:0] REG_OT_LIMIT     = 3'd6;
  localparam logic [2:0] REG_SENSOR_LIMIT = 3'd7;

  // Field and counter widths.
  localparam int DEV_W   = 11;
  localparam int COUNT_W = 16;
  localparam int MAG_W   = 10;
  localparam int CNT_W   = 7;
  localparam int CFG_W   = 7;

  localparam logic [COUNT_W-1:0] COUNT_MIN   = 16'd10;
  localparam logic [MAG_W-1:0]   STALL_DELTA = 10'd2;
  localparam logic [MAG_W-1:0]   MAG_MAX     = 10'h3FF;
  localparam logic [CNT_W-1:0]   CNT_MAX     = 7'd127;

  // Configuration registers.
  typedef struct packed {
    logic [2:0]        setpoint;
    logic [2:0]        hyst_up;
    logic signed [3:0] hyst_down;
    logic [1:0]        pulse_length;
    logic [5:0]        pulse_gap;
    logic [CNT_W-1:0]  stall_limit;
    logic [CNT_W-1:0]  overtime_limit;
    logic [CNT_W-1:0]  sensor_fault_limit;
  } cfg_t;

  // Controller state carried from tick to tick.
  typedef struct packed {
    logic [1:0]       motor_dir;
    logic [1:0]       pulse_left;
    logic [5:0]       gap_left;
    logic [CNT_W-1:0] overtime_count;
    logic [CNT_W-1:0] stall_count;
    logic [MAG_W-1:0] last_magnitude;
    logic [CNT_W-1:0] sensor_bad_count;
    logic [2:0]       current_error;
    logic             fault_latch;
    logic             pulse_enable;
  } state_t;

endpackage

@@ hw/rtl/pahc_sensor.sv @@
// Sensor check of one tick: flags low counts and latches a sensor fault.
// Depends on pahc_pkg.
`timescale 1ns / 1ps

module pahc_sensor (
  input  pahc_pkg::cfg_t             cfg,
  input  pahc_pkg::state_t           cur,
  input  logic [pahc_pkg::COUNT_W-1:0] count_a,
  input  logic [pahc_pkg::COUNT_W-1:0] count_b,
  output pahc_pkg::state_t           nxt,
  output logic                       raised
);
  import pahc_pkg::*;

  logic bad_a;
  logic bad_b;

  assign bad_a = count_a < COUNT_MIN;
  assign bad_b = count_b < COUNT_MIN;

  // Count bad ticks; a good tick after counted bad ones clears the error.
  always_comb begin
    nxt    = cur;
    raised = 1'b0;
    if (cfg.sensor_fault_limit != '0 && (bad_a || bad_b)) begin
      if (bad_a && bad_b) begin
        nxt.current_error = ERR_SENSOR_AB;
      end else if (bad_b) begin
        nxt.current_error = ERR_SENSOR_B;
      end else begin
        nxt.current_error = ERR_SENSOR_A;
      end
      if (cur.sensor_bad_count >= cfg.sensor_fault_limit) begin
        nxt.fault_latch      = 1'b1;
        nxt.sensor_bad_count = '0;
        raised               = 1'b1;
      end else begin
        nxt.sensor_bad_count = cur.sensor_bad_count + 7'd1;
      end
    end else if (cur.sensor_bad_count != '0) begin
      nxt.sensor_bad_count = '0;
      nxt.current_error    = ERR_NONE;
    end
  end

endmodule

@@ hw/rtl/pahc_drive.sv @@
// Actuator logic of one tick: lock band, pulse timing, stall and overtime faults.
// Depends on pahc_pkg.
`timescale 1ns / 1ps

module pahc_drive (
  input  pahc_pkg::cfg_t                  cfg,
  input  pahc_pkg::state_t                cur,
  input  logic signed [pahc_pkg::DEV_W-1:0] deviation,
  output pahc_pkg::state_t                nxt,
  output logic                            raised
);
  import pahc_pkg::*;

  logic [DEV_W-1:0]        dev_abs;
  logic [MAG_W-1:0]        mag;
  logic [MAG_W-1:0]        mag_diff;
  logic signed [DEV_W-1:0] hup_ext;
  logic signed [DEV_W-1:0] hdown_ext;
  logic                    at_up;
  logic                    at_down;
  logic                    moving;
  logic [CNT_W-1:0]        stall_cnt;
  logic [CNT_W-1:0]        ot_cnt;

  // Saturated magnitude of the deviation and the threshold compares.
  assign dev_abs   = deviation[DEV_W-1] ? DEV_W'(-deviation) : DEV_W'(deviation);
  assign mag       = dev_abs[DEV_W-1] ? MAG_MAX : dev_abs[MAG_W-1:0];
  assign mag_diff  = (cur.last_magnitude > mag) ? (cur.last_magnitude - mag)
                                                : (mag - cur.last_magnitude);
  assign hup_ext   = $signed({{(DEV_W-3){1'b0}}, cfg.hyst_up});
  assign hdown_ext = $signed({{(DEV_W-4){cfg.hyst_down[3]}}, cfg.hyst_down});
  assign at_up     = deviation >= hup_ext;
  assign at_down   = deviation <= hdown_ext;
  assign moving    = cur.motor_dir != DIR_LOCKED;

  always_comb begin
    nxt       = cur;
    raised    = 1'b0;
    stall_cnt = cur.stall_count;
    ot_cnt    = cur.overtime_count;
    if (cur.gap_left != '0) begin
      // Enforced idle after a pulse or a lock.
      nxt.gap_left = cur.gap_left - 6'd1;
    end else if (mag <= {{(MAG_W-3){1'b0}}, cfg.setpoint}) begin
      // Inside the setpoint band: lock a moving actuator.
      if (moving) begin
        nxt.overtime_count = '0;
        nxt.stall_count    = '0;
        nxt.pulse_enable   = 1'b0;
        nxt.motor_dir      = DIR_LOCKED;
        nxt.pulse_left     = '0;
        nxt.gap_left       = cfg.pulse_gap;
      end
    end else if (cur.pulse_left != '0) begin
      // A pulse is running; its last tick opens the gap.
      nxt.pulse_left = cur.pulse_left - 2'd1;
      if (cur.pulse_left == 2'd1) begin
        nxt.pulse_enable = 1'b0;
        nxt.gap_left     = cfg.pulse_gap;
      end
    end else if (cur.current_error != ERR_NONE && cur.current_error <= ERR_SENSOR_AB) begin
      // A standing sensor error blocks new pulses.
      nxt = cur;
    end else begin
      // Stall tracking while the deviation stays beyond the band.
      if (cfg.stall_limit != '0 && (at_up || at_down)) begin
        if (!moving) begin
          nxt.last_magnitude = mag;
        end else if (mag_diff < STALL_DELTA) begin
          if (cur.stall_count < CNT_MAX) begin
            stall_cnt = cur.stall_count + 7'd1;
          end
        end else begin
          stall_cnt          = '0;
          nxt.last_magnitude = mag;
        end
      end
      nxt.stall_count = stall_cnt;
      if (stall_cnt > cfg.stall_limit) begin
        nxt.current_error = ERR_STALL;
        nxt.stall_count   = '0;
        nxt.fault_latch   = 1'b1;
        raised            = 1'b1;
      end else begin
        // Pulse start; a left start skips the overtime check.
        if (cfg.overtime_limit != '0 && cur.overtime_count < CNT_MAX) begin
          ot_cnt = cur.overtime_count + 7'd1;
        end
        if (cfg.pulse_length != '0 &&
            (at_up || (!deviation[DEV_W-1] && deviation != '0 && moving))) begin
          nxt.motor_dir      = DIR_LEFT;
          nxt.overtime_count = ot_cnt;
          nxt.pulse_left     = cfg.pulse_length;
          nxt.pulse_enable   = 1'b1;
        end else begin
          if (cfg.pulse_length != '0 && (at_down || (deviation[DEV_W-1] && moving))) begin
            nxt.motor_dir      = DIR_RIGHT;
            nxt.overtime_count = ot_cnt;
            nxt.pulse_left     = cfg.pulse_length;
            nxt.pulse_enable   = 1'b1;
          end
          if (nxt.overtime_count > cfg.overtime_limit) begin
            nxt.current_error  = ERR_OVERTIME;
            nxt.overtime_count = '0;
            nxt.fault_latch    = 1'b1;
            raised             = 1'b1;
          end
        end
      end
    end
  end

endmodule

@@ hw/rtl/pulsed_actuator_hysteresis_controller.sv @@
// Pulsed actuator hysteresis controller, top level.
// An accepted word waits in the input register; its result word goes to the result register.
// Throughput: one word per cycle while out_stall is low; the single state update between
// the input register and the result register sets that figure. Reset (rst, synchronous)
// loads the default configuration, clears the controller state and empties both registers.
// Depends on pahc_pkg, pahc_sensor and pahc_drive.
`timescale 1ns / 1ps

module pulsed_actuator_hysteresis_controller (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [pahc_pkg::DEV_W-1:0] deviation,
  input  logic [pahc_pkg::COUNT_W-1:0]      count_a,
  input  logic [pahc_pkg::COUNT_W-1:0]      count_b,
  input  logic                              restart,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              pulse_on,
  output logic [1:0]                        direction,
  output logic                              fault,
  output logic [2:0]                        error_code,
  output logic                              error_raised,
  input  logic                              cfg_write,
  input  logic [2:0]                        cfg_index,
  input  logic [pahc_pkg::CFG_W-1:0]        cfg_data
);
  import pahc_pkg::*;

  cfg_t                    cfg;
  state_t                  state;
  state_t                  state_next;
  state_t                  sensed;
  state_t                  driven;
  logic                    sensor_raised;
  logic                    drive_raised;
  logic                    s1_valid;
  logic signed [DEV_W-1:0] s1_deviation;
  logic [COUNT_W-1:0]      s1_count_a;
  logic [COUNT_W-1:0]      s1_count_b;
  logic                    s1_restart;
  logic                    out_ready;
  logic                    advance;
  logic                    raised_next;

  assign out_ready = !out_valid || !out_stall;
  assign in_stall  = s1_valid && !out_ready;
  assign advance   = s1_valid && out_ready;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.setpoint           <= 3'd0;
      cfg.hyst_up            <= 3'd4;
      cfg.hyst_down          <= -4'sd4;
      cfg.pulse_length       <= 2'd1;
      cfg.pulse_gap          <= 6'd60;
      cfg.stall_limit        <= 7'd0;
      cfg.overtime_limit     <= 7'd0;
      cfg.sensor_fault_limit <= 7'd30;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_SETPOINT:     cfg.setpoint           <= cfg_data[2:0];
        REG_HYST_UP:      cfg.hyst_up            <= cfg_data[2:0];
        REG_HYST_DOWN:    cfg.hyst_down          <= $signed(cfg_data[3:0]);
        REG_PULSE_LENGTH: cfg.pulse_length       <= cfg_data[1:0];
        REG_PULSE_GAP:    cfg.pulse_gap          <= cfg_data[5:0];
        REG_STALL_LIMIT:  cfg.stall_limit        <= cfg_data;
        REG_OT_LIMIT:     cfg.overtime_limit     <= cfg_data;
        REG_SENSOR_LIMIT: cfg.sensor_fault_limit <= cfg_data;
        default: cfg <= cfg;
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      s1_valid <= 1'b1;
    end else if (out_ready) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_deviation <= deviation;
      s1_count_a   <= count_a;
      s1_count_b   <= count_b;
      s1_restart   <= restart;
    end
  end

  // Sensor check, then actuator logic on the checked state.
  pahc_sensor u_sensor (
    .cfg     (cfg),
    .cur     (state),
    .count_a (s1_count_a),
    .count_b (s1_count_b),
    .nxt     (sensed),
    .raised  (sensor_raised)
  );

  pahc_drive u_drive (
    .cfg       (cfg),
    .cur       (sensed),
    .deviation (s1_deviation),
    .nxt       (driven),
    .raised    (drive_raised)
  );

  // A restart clears motion, error, fault and the overtime count but keeps the stall and sensor counters.
  always_comb begin
    state_next  = driven;
    raised_next = sensor_raised || drive_raised;
    if (s1_restart) begin
      state_next                = state;
      state_next.motor_dir      = DIR_LOCKED;
      state_next.pulse_left     = '0;
      state_next.gap_left       = '0;
      state_next.overtime_count = '0;
      state_next.pulse_enable   = 1'b0;
      state_next.fault_latch    = 1'b0;
      state_next.current_error  = ERR_NONE;
      raised_next               = 1'b0;
    end
  end

  // Controller state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_ready) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      pulse_on     <= state_next.pulse_enable;
      direction    <= state_next.motor_dir;
      fault        <= state_next.fault_latch;
      error_code   <= state_next.current_error;
      error_raised <= raised_next;
    end
  end

endmodule

@@ hw/rtl/pahc_checker.sv @@
// Port checker of the pulsed actuator controller, bound to the top level.
// Depends on pahc_pkg and pulsed_actuator_hysteresis_controller_macros.svh.
`timescale 1ns / 1ps
`include "pulsed_actuator_hysteresis_controller_macros.svh"

module pahc_port_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_stall,
  input logic       pulse_on,
  input logic [1:0] direction,
  input logic       fault,
  input logic [2:0] error_code,
  input logic       error_raised
);
  import pahc_pkg::*;

  logic [7:0] res_word;

  // All result fields packed together, so that one stability check covers them.
  assign res_word = {pulse_on, direction, fault, error_code, error_raised};

  // A stalled result word stays and holds its value.
  `PAHC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(res_word), "result word changed while stalled")

  // A raised fault is latched in the same word.
  `PAHC_ASSERT_SAME(a_raise_latched, out_valid && error_raised, fault, "fault raised but not latched")

  // A raised fault always carries an error code.
  `PAHC_ASSERT_SAME(a_raise_code, out_valid && error_raised, error_code != ERR_NONE && error_code <= ERR_OVERTIME, "fault raised without a valid error code")

  // The pulse output is only on while the actuator has a direction.
  `PAHC_ASSERT_SAME(a_pulse_dir, out_valid && pulse_on, direction == DIR_LEFT || direction == DIR_RIGHT, "pulse on while locked")

endmodule

bind pulsed_actuator_hysteresis_controller pahc_port_checker u_pahc_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .pulse_on     (pulse_on),
  .direction    (direction),
  .fault        (fault),
  .error_code   (error_code),
  .error_raised (error_raised)
);

@@ dv/pahc_checker.sv @@
// Checker for the pulsed actuator hysteresis controller: it tracks register writes,
// predicts one result word per accepted input word and compares the words returned.
// Depends on pahc_pkg for widths, directions, error codes and register indexes.
`timescale 1ns / 1ps

module pahc_checker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  input  logic                              in_stall,
  input  logic signed [pahc_pkg::DEV_W-1:0] deviation,
  input  logic [pahc_pkg::COUNT_W-1:0]      count_a,
  input  logic [pahc_pkg::COUNT_W-1:0]      count_b,
  input  logic                              restart,
  input  logic                              out_valid,
  input  logic                              out_stall,
  input  logic                              pulse_on,
  input  logic [1:0]                        direction,
  input  logic                              fault,
  input  logic [2:0]                        error_code,
  input  logic                              error_raised,
  input  logic                              cfg_write,
  input  logic [2:0]                        cfg_index,
  input  logic [pahc_pkg::CFG_W-1:0]        cfg_data,
  output int                                mismatches,
  output int                                pending,
  output int                                compared,
  output int                                raised_seen
);

  import pahc_pkg::*;

  localparam int PRINT_CAP = 200;

  typedef struct packed {
    logic       pulse_on;
    logic [1:0] direction;
    logic       fault;
    logic [2:0] error_code;
    logic       error_raised;
  } actuator_word_t;

  // Shadow copy of the configuration registers.
  logic [2:0]        sp_cfg;
  logic [2:0]        up_cfg;
  logic signed [3:0] down_cfg;
  logic [1:0]        len_cfg;
  logic [5:0]        gap_cfg;
  logic [CNT_W-1:0]  stall_lim_cfg;
  logic [CNT_W-1:0]  ot_lim_cfg;
  logic [CNT_W-1:0]  sensor_lim_cfg;

  // Predicted controller state.
  logic [1:0]       dir_q;
  logic [1:0]       pulse_ticks;
  logic [5:0]       gap_ticks;
  logic [CNT_W-1:0] push_count;
  logic [CNT_W-1:0] still_count;
  logic [MAG_W-1:0] ref_mag;
  logic [CNT_W-1:0] bad_ticks;
  logic [2:0]       err_q;
  logic             fault_q;
  logic             pulse_q;

  // Result words predicted but not yet returned, oldest first.
  actuator_word_t tick_forecast[$];

  function automatic void clear_model();
    sp_cfg         = 3'd0;
    up_cfg         = 3'd4;
    down_cfg       = -4'sd4;
    len_cfg        = 2'd1;
    gap_cfg        = 6'd60;
    stall_lim_cfg  = '0;
    ot_lim_cfg     = '0;
    sensor_lim_cfg = 7'd30;
    dir_q          = DIR_LOCKED;
    pulse_ticks    = '0;
    gap_ticks      = '0;
    push_count     = '0;
    still_count    = '0;
    ref_mag        = '0;
    bad_ticks      = '0;
    err_q          = ERR_NONE;
    fault_q        = 1'b0;
    pulse_q        = 1'b0;
  endfunction

  function automatic void write_register(input logic [2:0] idx, input logic [CFG_W-1:0] data);
    case (idx)
      REG_SETPOINT:     sp_cfg = data[2:0];
      REG_HYST_UP:      up_cfg = data[2:0];
      REG_HYST_DOWN:    down_cfg = data[3:0];
      REG_PULSE_LENGTH: len_cfg = data[1:0];
      REG_PULSE_GAP:    gap_cfg = data[5:0];
      REG_STALL_LIMIT:  stall_lim_cfg = data;
      REG_OT_LIMIT:     ot_lim_cfg = data;
      REG_SENSOR_LIMIT: sensor_lim_cfg = data;
      default: ;
    endcase
  endfunction

  // Sensor check: low counts set a sensor error, and a long run of them latches a fault.
  function automatic bit check_counts(input logic [COUNT_W-1:0] a, input logic [COUNT_W-1:0] b);
    bit low_a;
    bit low_b;
    low_a = a < COUNT_MIN;
    low_b = b < COUNT_MIN;
    if (sensor_lim_cfg != 0 && (low_a || low_b)) begin
      if (low_a && low_b) err_q = ERR_SENSOR_AB;
      else if (low_b) err_q = ERR_SENSOR_B;
      else err_q = ERR_SENSOR_A;
      if (bad_ticks >= sensor_lim_cfg) begin
        fault_q = 1'b1;
        bad_ticks = '0;
        return 1'b1;
      end
      bad_ticks++;
      return 1'b0;
    end
    // The error clears only while bad ticks are still being counted.
    if (bad_ticks != 0) begin
      bad_ticks = '0;
      err_q = ERR_NONE;
    end
    return 1'b0;
  endfunction

  function automatic void begin_pulse(input logic [1:0] dir);
    dir_q = dir;
    if (ot_lim_cfg != 0 && push_count != CNT_MAX) push_count++;
    pulse_ticks = len_cfg;
    pulse_q = 1'b1;
  endfunction

  // Actuator logic for one tick; returns whether a stall or overtime fault was raised.
  function automatic bit steer_actuator(input logic signed [DEV_W-1:0] dev);
    int d;
    int mag;
    int diff;
    bit beyond;
    d = int'(dev);
    mag = (d < 0) ? -d : d;
    if (mag > 1023) mag = 1023;

    if (gap_ticks != 0) begin
      gap_ticks--;
      return 1'b0;
    end

    // Inside the setpoint band a moving actuator locks and the gap starts.
    if (mag <= int'(sp_cfg)) begin
      if (dir_q == DIR_LOCKED) return 1'b0;
      push_count  = '0;
      still_count = '0;
      pulse_q     = 1'b0;
      dir_q       = DIR_LOCKED;
      pulse_ticks = '0;
      gap_ticks   = gap_cfg;
      return 1'b0;
    end

    if (pulse_ticks != 0) begin
      pulse_ticks--;
      if (pulse_ticks == 0) begin
        pulse_q = 1'b0;
        gap_ticks = gap_cfg;
      end
      return 1'b0;
    end

    // A standing sensor error blocks any new pulse.
    if (err_q inside {ERR_SENSOR_A, ERR_SENSOR_B, ERR_SENSOR_AB}) return 1'b0;

    // Stall tracking: the magnitude barely moving while the actuator moves.
    beyond = (d >= int'(up_cfg)) || (d <= int'(down_cfg));
    if (stall_lim_cfg != 0 && beyond) begin
      if (dir_q == DIR_LOCKED) begin
        ref_mag = MAG_W'(mag);
      end else begin
        diff = int'(ref_mag) - mag;
        if (diff < 0) diff = -diff;
        if (diff < int'(STALL_DELTA)) begin
          if (still_count != CNT_MAX) still_count++;
        end else begin
          still_count = '0;
          ref_mag = MAG_W'(mag);
        end
      end
    end
    if (still_count > stall_lim_cfg) begin
      err_q = ERR_STALL;
      still_count = '0;
      fault_q = 1'b1;
      return 1'b1;
    end

    // A left pulse skips the overtime check on the tick that starts it.
    if (len_cfg != 0) begin
      if (d >= int'(up_cfg) || (d > 0 && dir_q != DIR_LOCKED)) begin
        begin_pulse(DIR_LEFT);
        return 1'b0;
      end
      if (d <= int'(down_cfg) || (d < 0 && dir_q != DIR_LOCKED)) begin_pulse(DIR_RIGHT);
    end

    if (push_count > ot_lim_cfg) begin
      err_q = ERR_OVERTIME;
      push_count = '0;
      fault_q = 1'b1;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic actuator_word_t advance_tick(input logic signed [DEV_W-1:0] dev,
                                                  input logic [COUNT_W-1:0] a,
                                                  input logic [COUNT_W-1:0] b,
                                                  input logic rs);
    actuator_word_t w;
    bit raised;
    raised = 1'b0;
    if (rs) begin
      // Restart keeps the stall reference and the bad tick count.
      dir_q       = DIR_LOCKED;
      pulse_ticks = '0;
      gap_ticks   = '0;
      push_count  = '0;
      pulse_q     = 1'b0;
      fault_q     = 1'b0;
      err_q       = ERR_NONE;
    end else begin
      raised = check_counts(a, b);
      if (steer_actuator(dev)) raised = 1'b1;
    end
    w.pulse_on     = pulse_q;
    w.direction    = dir_q;
    w.fault        = fault_q;
    w.error_code   = err_q;
    w.error_raised = raised;
    return w;
  endfunction

  // Beyond the first 200 mismatches only the count goes on.
  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatches < PRINT_CAP)
      $display("[%0t] %s mismatch: got %0d, expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  task automatic compare_result();
    actuator_word_t want;
    if (tick_forecast.size() == 0) begin
      report_mismatch("result word count", compared + 1, compared);
      return;
    end
    want = tick_forecast.pop_front();
    compared++;
    if (pulse_on !== want.pulse_on)
      report_mismatch("pulse_on", 32'(pulse_on), 32'(want.pulse_on));
    if (direction !== want.direction)
      report_mismatch("direction", 32'(direction), 32'(want.direction));
    if (fault !== want.fault) report_mismatch("fault", 32'(fault), 32'(want.fault));
    if (error_code !== want.error_code)
      report_mismatch("error_code", 32'(error_code), 32'(want.error_code));
    if (error_raised !== want.error_raised)
      report_mismatch("error_raised", 32'(error_raised), 32'(want.error_raised));
    if (want.error_raised) raised_seen++;
  endtask

  // Results are checked before the word accepted at the same edge is predicted.
  always @(posedge clk) begin
    if (rst) begin
      clear_model();
      tick_forecast.delete();
      mismatches = 0;
      compared = 0;
      raised_seen = 0;
    end else begin
      if (out_valid && !out_stall) compare_result();
      if (cfg_write) write_register(cfg_index, cfg_data);
      if (in_valid && !in_stall)
        tick_forecast.push_back(advance_tick(deviation, count_a, count_b, restart));
    end
    pending <= tick_forecast.size();
  end

endmodule

@@ dv/tb_pulsed_actuator_hysteresis_controller.sv @@
// Testbench top of the pulsed actuator hysteresis controller: clock, reset, stimulus,
// receiver stalls, watchdog and verdict. Depends on pahc_pkg, the block and pahc_checker.
`timescale 1ns / 1ps

module tb_pulsed_actuator_hysteresis_controller;

  import pahc_pkg::*;

  localparam int IDLE_LIMIT    = 3000;
  localparam int HOLD_CYCLES   = 160;
  localparam int SETTLE_CYCLES = 4;
  localparam logic [COUNT_W-1:0] GOOD_COUNT = 16'd1000;

  typedef enum int {FLOW_FREE, FLOW_RANDOM, FLOW_PATTERN, FLOW_HEAVY} flow_mode_t;

  logic                      clk;
  logic                      rst;
  logic                      in_valid;
  logic                      in_stall;
  logic signed [DEV_W-1:0]   deviation;
  logic [COUNT_W-1:0]        count_a;
  logic [COUNT_W-1:0]        count_b;
  logic                      restart;
  logic                      out_valid;
  logic                      out_stall;
  logic                      pulse_on;
  logic [1:0]                direction;
  logic                      fault;
  logic [2:0]                error_code;
  logic                      error_raised;
  logic                      cfg_write;
  logic [2:0]                cfg_index;
  logic [CFG_W-1:0]          cfg_data;

  int mismatches;
  int pending;
  int compared;
  int raised_seen;

  int words_sent;
  int settings_loaded;
  int idle_cycles;
  int burst_left;
  int walk_dev;
  int bad_run;
  bit steady;
  int holdoff_asked;
  int holdoff_done;
  flow_mode_t flow_mode;
  int flow_left;
  int pattern_step;

  pulsed_actuator_hysteresis_controller i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .deviation    (deviation),
    .count_a      (count_a),
    .count_b      (count_b),
    .restart      (restart),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .pulse_on     (pulse_on),
    .direction    (direction),
    .fault        (fault),
    .error_code   (error_code),
    .error_raised (error_raised),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  pahc_checker i_checker (.*);

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Watchdog: ends the run when no word moves on either channel for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Watchdog: no word accepted for %0d cycles", IDLE_LIMIT);
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Receiver: stall modes of random length, plus long hold-offs on request.
  initial begin
    out_stall = 1'b0;
    flow_mode = FLOW_FREE;
    flow_left = 0;
    pattern_step = 0;
    forever begin
      @(negedge clk);
      if (holdoff_asked != holdoff_done) begin
        out_stall = 1'b1;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        holdoff_done++;
      end else begin
        if (flow_left == 0) begin
          flow_mode = flow_mode_t'($urandom_range(0, 3));
          flow_left = $urandom_range(40, 300);
        end
        flow_left--;
        pattern_step++;
        case (flow_mode)
          FLOW_FREE:    out_stall = 1'b0;
          FLOW_RANDOM:  out_stall = ($urandom_range(0, 99) < 40);
          FLOW_PATTERN: out_stall = ((pattern_step % 7) < 3);
          default:      out_stall = ($urandom_range(0, 99) < 80);
        endcase
      end
    end
  end

  // Offers one word and waits for it to be taken; bursts end in random gaps.
  task automatic drive_word(input logic signed [DEV_W-1:0] dev, input logic [COUNT_W-1:0] a,
                            input logic [COUNT_W-1:0] b, input logic rs);
    int gap;
    @(negedge clk);
    in_valid  = 1'b1;
    deviation = dev;
    count_a   = a;
    count_b   = b;
    restart   = rs;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    words_sent++;
    if (!steady) begin
      burst_left--;
      if (burst_left <= 0) begin
        burst_left = $urandom_range(1, 40);
        gap = $urandom_range(0, 6);
        if (gap != 0) begin
          @(negedge clk);
          in_valid = 1'b0;
          repeat (gap - 1) @(negedge clk);
        end
      end
    end
  endtask

  // Stops offering words until every predicted result word has come back.
  task automatic drain_results();
    @(negedge clk);
    in_valid = 1'b0;
    wait (pending == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
  endtask

  // Writes every register while the block is idle.
  task automatic load_settings(input logic [2:0] sp, input logic [2:0] up,
                               input logic signed [3:0] down, input logic [1:0] len,
                               input logic [5:0] gap, input logic [CNT_W-1:0] st,
                               input logic [CNT_W-1:0] ot, input logic [CNT_W-1:0] sn);
    drain_results();
    write_reg(REG_SETPOINT, CFG_W'(sp));
    write_reg(REG_HYST_UP, CFG_W'(up));
    write_reg(REG_HYST_DOWN, CFG_W'(down));
    write_reg(REG_PULSE_LENGTH, CFG_W'(len));
    write_reg(REG_PULSE_GAP, CFG_W'(gap));
    write_reg(REG_STALL_LIMIT, st);
    write_reg(REG_OT_LIMIT, ot);
    write_reg(REG_SENSOR_LIMIT, sn);
    @(negedge clk);
    cfg_write = 1'b0;
    settings_loaded++;
  endtask

  // Mostly a slowly wandering deviation with runs of low sensor counts; some noise.
  task automatic send_random_tick();
    int pick;
    int mag;
    logic [COUNT_W-1:0] a;
    logic [COUNT_W-1:0] b;
    pick = $urandom_range(0, 99);
    if (pick < 3) begin
      drive_word(DEV_W'($urandom), 16'($urandom), 16'($urandom), 1'b1);
      return;
    end
    if (pick < 10) begin
      drive_word(DEV_W'($urandom), 16'($urandom), 16'($urandom), 1'b0);
      return;
    end

    // Next point of the deviation walk; holding still provokes stall detection.
    pick = $urandom_range(0, 99);
    mag = (walk_dev < 0) ? -walk_dev : walk_dev;
    if (pick >= 30) begin
      if (pick < 55) walk_dev += $urandom_range(0, 1) ? 1 : -1;
      else if (pick < 70) walk_dev += $urandom_range(0, 1) ? 3 : -2;
      else if (pick < 85) walk_dev += (walk_dev > 0 ? -1 : 1) * $urandom_range(1, mag / 2 + 1);
      else if (pick < 95) walk_dev = $urandom_range(0, 24) - 12;
      else walk_dev = $urandom_range(0, 2000) - 1000;
    end
    if (walk_dev > 1000) walk_dev = 1000;
    if (walk_dev < -1000) walk_dev = -1000;

    // Sensor counts: good most of the time, with occasional runs of low counts.
    if (bad_run == 0 && $urandom_range(0, 99) < 5)
      bad_run = ($urandom_range(0, 1) != 0) ? 1 : $urandom_range(2, 14);
    a = 16'($urandom_range(10, 65535));
    b = 16'($urandom_range(10, 65535));
    if (bad_run > 0) begin
      bad_run--;
      case ($urandom_range(0, 2))
        0: a = 16'($urandom_range(0, 9));
        1: b = 16'($urandom_range(0, 9));
        default: begin
          a = 16'($urandom_range(0, 9));
          b = 16'($urandom_range(0, 9));
        end
      endcase
    end
    drive_word(DEV_W'(walk_dev), a, b, 1'b0);
  endtask

  // One random phase with a long receiver hold-off, and a full pause if it runs past 200 words.
  task automatic run_random_phase(input int n);
    for (int i = 0; i < n; i++) begin
      if (i == 100) begin
        holdoff_asked++;
        steady = 1'b1;
        repeat (30) send_random_tick();
        steady = 1'b0;
      end
      if (i == 200) drain_results();
      send_random_tick();
    end
  endtask

  // Main sequence: reset, directed words, then random phases under several settings.
  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    deviation = '0;
    count_a = '0;
    count_b = '0;
    restart = 1'b0;
    cfg_write = 1'b0;
    cfg_index = REG_SETPOINT;
    cfg_data = '0;
    steady = 1'b0;
    burst_left = 1;
    walk_dev = 0;
    bad_run = 0;
    holdoff_asked = 0;
    holdoff_done = 0;
    repeat (8) @(negedge clk);
    rst = 1'b0;

    // Short pulses with no gap so that stall, overtime and sensor faults come quickly.
    load_settings(3'd1, 3'd3, -4'sd3, 2'd1, 6'd0, 7'd2, 7'd3, 7'd2);
    drive_word(11'sd0, GOOD_COUNT, GOOD_COUNT, 1'b0);
    drive_word(11'sd5, GOOD_COUNT, GOOD_COUNT, 1'b0);
    drive_word(11'sd5, GOOD_COUNT, GOOD_COUNT, 1'b0);
    drive_word(11'sd5, GOOD_COUNT, GOOD_COUNT, 1'b0);
    drive_word(11'sd5, GOOD_COUNT, GOOD_COUNT, 1'b0);
    drive_word(11'sd6, GOOD_COUNT, GOOD_COUNT, 1'b0);
    drive_word(11'sd6, GOOD_COUNT, GOOD_COUNT, 1'b0);
    // Deviation has hardly changed for several pulses: stall fault.
    drive_word(11'sd6, GOOD_COUNT, GOOD_COUNT, 1'b0);
    // Restart with the other fields at odd values, which must be ignored.
    drive_word(-11'sd1, 16'd0, 16'hFFFF, 1'b1);
    // Right pulses one after another until the overtime fault.
    drive_word(-11'sd10, GOOD_COUNT, GOOD_COUNT, 1'b0);
    drive_word(-11'sd10, GOOD_COUNT, GOOD_COUNT, 1'b0);
    drive_word(-11'sd20, GOOD_COUNT, GOOD_COUNT, 1'b0);
    drive_word(-11'sd20, GOOD_COUNT, GOOD_COUNT, 1'b0);
    drive_word(-11'sd30, GOOD_COUNT, GOOD_COUNT, 1'b0);
    drive_word(-11'sd30, GOOD_COUNT, GOOD_COUNT, 1'b0);
    drive_word(-11'sd40, GOOD_COUNT, GOOD_COUNT, 1'b0);
    // Back inside the setpoint band while moving: the actuator locks.
    drive_word(11'sd1, GOOD_COUNT, GOOD_COUNT, 1'b0);
    // Sensor A low, then B low, then both low past the limit.
    drive_word(11'sd50, 16'd9, GOOD_COUNT, 1'b0);
    drive_word(11'sd50, GOOD_COUNT, 16'd0, 1'b0);
    drive_word(11'sd50, 16'd0, 16'd0, 1'b0);
    // A good tick right after the fault does not clear the sensor error.
    drive_word(-11'sd1024, 16'hFFFF, 16'hFFFF, 1'b0);
    drive_word(11'sd1023, 16'd9, 16'd9, 1'b0);
    drive_word(11'sd1023, 16'd10, 16'hFFFF, 1'b0);
    drive_word(-11'sd1024, GOOD_COUNT, GOOD_COUNT, 1'b0);

    // Register extremes, then the reset values, then random settings.
    load_settings(3'd0, 3'd0, 4'sd0, 2'd3, 6'd60, 7'd99, 7'd99, 7'd99);
    run_random_phase(200);
    load_settings(3'd5, 3'd5, -4'sd5, 2'd0, 6'd0, 7'd0, 7'd0, 7'd0);
    run_random_phase(180);
    load_settings(3'd0, 3'd4, -4'sd4, 2'd1, 6'd60, 7'd0, 7'd0, 7'd30);
    run_random_phase(180);
    repeat (5) begin
      load_settings(3'($urandom_range(0, 5)), 3'($urandom_range(0, 5)),
                    4'(-int'($urandom_range(0, 5))),
                    ($urandom_range(0, 3) == 0) ? 2'd0 : 2'($urandom_range(1, 3)),
                    ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 60))
                                                : 6'($urandom_range(0, 3)),
                    7'($urandom_range(0, 8)), 7'($urandom_range(0, 8)),
                    7'($urandom_range(0, 12)));
      run_random_phase(220);
    end
    drain_results();

    $display("Sent %0d input words under %0d register settings; %0d result words compared.",
             words_sent, settings_loaded, compared);
    $display("%0d words raised a fault; the receiver held off %0d times to back up the input.",
             raised_seen, holdoff_done);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
